### rtl/core/tw_spi_pkg.sv
// shared types, codes and defaults for the three-wire spi register master
package tw_spi_pkg;

    localparam int DEF_DATA_BITS       = 16;
    localparam int DEF_HEADER_BITS     = 9;
    localparam int DEF_TURNAROUND_BITS = 2;
    localparam int DEF_TRAILING_BITS   = 2;

    localparam int ADDR_W      = 7;
    localparam int WORD_W      = 16;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 24;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_TURN   = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_TRAIL  = 2'd3;

    typedef struct packed {
        logic              kind;
        logic              is_read;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
        logic              sample;
        logic [1:0]        phase;
        logic              cap_en;
        logic              last;
    } t_cmd;

endpackage

### rtl/core/three_wire_spi_register_master.sv
// top level of the three-wire spi register master
//
// usage: requests arrive on the s_axis channel. tuser selects the kind:
// a start request latches direction, 7-bit address and write word; a tick
// request stands for one serial clock period and carries the line level
// sampled in the previous period. every tick of a running frame gives one
// pin result on m_axis (select_n, line_out, line_drive, read_word, tlast).
// ticks while idle and starts while a frame runs give no result.
// a frame is header periods, turnaround periods on reads, data periods,
// then trailing periods with select high; tlast marks the final period
// and its read_word holds the sampled data word.
// throughput: one request per cycle while the queue has room; the front
// end counts periods in one step and the back end shifts once per tick.
// a tick's result passes a queue entry, then the output register, on its
// way to m_axis.
// reset: synchronous, active low; ends any frame and empties the queue.
// stall: while m_axis is held off, up to two requests wait in the queue
// and the result register holds; s_axis tready falls once the queue fills.
module three_wire_spi_register_master #(
    parameter int DATA_BITS       = tw_spi_pkg::DEF_DATA_BITS,
    parameter int HEADER_BITS     = tw_spi_pkg::DEF_HEADER_BITS,
    parameter int TURNAROUND_BITS = tw_spi_pkg::DEF_TURNAROUND_BITS,
    parameter int TRAILING_BITS   = tw_spi_pkg::DEF_TRAILING_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // is_read, reg_address[6:0], write_data[15:0], line_sample, zero fill
    input  logic [tw_spi_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // req_type
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // select_n, line_out, line_drive, read_word[15:0], zero fill
    output logic [tw_spi_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast
);
    import tw_spi_pkg::*;

    logic              push;
    logic              full;
    logic              q_valid;
    logic              pop;
    t_cmd              push_cmd;
    t_cmd              pop_cmd;
    logic              sel_n;
    logic              line_out;
    logic              line_drive;
    logic [WORD_W-1:0] read_word;

    tw_spi_front #(
        .DATA_BITS       (DATA_BITS),
        .HEADER_BITS     (HEADER_BITS),
        .TURNAROUND_BITS (TURNAROUND_BITS),
        .TRAILING_BITS   (TRAILING_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_req_type    (s_axis_tuser),
        .i_is_read     (s_axis_tdata[0]),
        .i_reg_address (s_axis_tdata[7:1]),
        .i_write_data  (s_axis_tdata[23:8]),
        .i_line_sample (s_axis_tdata[24]),
        .i_full        (full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    tw_spi_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_cmd   (pop_cmd)
    );

    tw_spi_back #(
        .DATA_BITS     (DATA_BITS),
        .HEADER_BITS   (HEADER_BITS),
        .TRAILING_BITS (TRAILING_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .o_pop        (pop),
        .i_cmd        (pop_cmd),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_select_n   (sel_n),
        .o_line_out   (line_out),
        .o_line_drive (line_drive),
        .o_read_word  (read_word),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, read_word, line_drive, line_out, sel_n};

    // a released line carries no bit
    a_released_low : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[2]) |-> !m_axis_tdata[1])
        else $error("line_out high while line released");

    // read word only on the final period
    a_word_on_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[18:3] == '0))
        else $error("read word outside last period");

    // with trailing periods, the final period lies in the trailing part, select deasserted
    a_last_deselected : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast && (TRAILING_BITS > 0)) |-> m_axis_tdata[0])
        else $error("select asserted on final period");

    // the queue never takes a push past its depth
    a_queue_flow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (full && !pop) |=> !push)
        else $error("request pushed into full queue");

endmodule

### rtl/core/tw_spi_front.sv
// front end: accepts requests, tracks the frame position and issues commands
module tw_spi_front #(
    parameter int DATA_BITS       = 16,
    parameter int HEADER_BITS     = 9,
    parameter int TURNAROUND_BITS = 2,
    parameter int TRAILING_BITS   = 2
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_req_type,
    input  logic                                 i_is_read,
    input  logic [tw_spi_pkg::ADDR_W-1:0]        i_reg_address,
    input  logic [tw_spi_pkg::WORD_W-1:0]        i_write_data,
    input  logic                                 i_line_sample,
    input  logic                                 i_full,
    output logic                                 o_push,
    output tw_spi_pkg::t_cmd                     o_cmd
);
    import tw_spi_pkg::*;

    localparam int TOTAL_MAX = HEADER_BITS + TURNAROUND_BITS + DATA_BITS + TRAILING_BITS;
    localparam int CW        = $clog2(TOTAL_MAX + 1);

    localparam logic [CW-1:0] HB    = CW'(HEADER_BITS);
    localparam logic [CW-1:0] D0_W  = CW'(HEADER_BITS);
    localparam logic [CW-1:0] D0_R  = CW'(HEADER_BITS + TURNAROUND_BITS);
    localparam logic [CW-1:0] D1_W  = CW'(HEADER_BITS + DATA_BITS);
    localparam logic [CW-1:0] D1_R  = CW'(HEADER_BITS + TURNAROUND_BITS + DATA_BITS);
    localparam logic [CW-1:0] END_W = CW'(HEADER_BITS + DATA_BITS + TRAILING_BITS - 1);
    localparam logic [CW-1:0] END_R = CW'(TOTAL_MAX - 1);

    logic          r_busy;
    logic          r_read;
    logic [CW-1:0] r_count;

    logic          accept;
    logic          is_start;
    logic [CW-1:0] d0;
    logic [CW-1:0] d1;
    logic [CW-1:0] last_p;
    logic          at_end;
    logic [1:0]    phase;

    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign is_start = (i_req_type == REQ_START);

    assign d0     = r_read ? D0_R : D0_W;
    assign d1     = r_read ? D1_R : D1_W;
    assign last_p = r_read ? END_R : END_W;
    assign at_end = (r_count == last_p);

    always_comb begin
        priority if (r_count < HB) begin
            phase = PH_HEADER;
        end else if (r_count < d0) begin
            phase = PH_TURN;
        end else if (r_count < d1) begin
            phase = PH_DATA;
        end else begin
            phase = PH_TRAIL;
        end
    end

    assign o_push = accept && (is_start ? !r_busy : r_busy);

    always_comb begin
        o_cmd.kind    = is_start ? REQ_START : REQ_TICK;
        o_cmd.is_read = i_is_read;
        o_cmd.addr    = i_reg_address;
        o_cmd.wdata   = i_write_data;
        o_cmd.sample  = i_line_sample;
        o_cmd.phase   = phase;
        o_cmd.cap_en  = (r_count > d0) && (r_count <= d1);
        o_cmd.last    = at_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_read  <= 1'b0;
            r_count <= '0;
        end else if (o_push) begin
            if (is_start) begin
                r_busy  <= 1'b1;
                r_read  <= i_is_read;
                r_count <= '0;
            end else if (at_end) begin
                r_busy  <= 1'b0;
                r_count <= '0;
            end else begin
                r_count <= r_count + 1'b1;
            end
        end
    end

endmodule

### rtl/core/tw_spi_cmd_fifo.sv
// two-entry command queue between front and back end
module tw_spi_cmd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tw_spi_pkg::t_cmd i_cmd,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output tw_spi_pkg::t_cmd o_cmd
);
    import tw_spi_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/core/tw_spi_back.sv
// back end: shift registers, capture and the registered pin result
module tw_spi_back #(
    parameter int DATA_BITS     = 16,
    parameter int HEADER_BITS   = 9,
    parameter int TRAILING_BITS = 2
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_pop,
    input  tw_spi_pkg::t_cmd                     i_cmd,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_select_n,
    output logic                                 o_line_out,
    output logic                                 o_line_drive,
    output logic [tw_spi_pkg::WORD_W-1:0]        o_read_word,
    output logic                                 o_last
);
    import tw_spi_pkg::*;

    logic [HEADER_BITS-1:0] r_header;
    logic [DATA_BITS-1:0]   r_data;
    logic [DATA_BITS-1:0]   r_capture;
    logic                   r_read;

    logic                   r_out_valid;
    logic                   r_sel;
    logic                   r_lo;
    logic                   r_drv;
    logic [WORD_W-1:0]      r_word;
    logic                   r_last;

    logic                   is_load;
    logic                   out_free;
    logic                   do_tick;
    logic                   do_load;
    logic [DATA_BITS-1:0]   n_capture;
    logic [DATA_BITS-1:0]   word;
    logic [31:0]            word_ext;
    logic                   n_sel;
    logic                   n_lo;
    logic                   n_drv;

    assign is_load  = (i_cmd.kind == REQ_START);
    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = i_valid && (is_load || out_free);
    assign do_load  = o_pop && is_load;
    assign do_tick  = o_pop && !is_load;

    assign n_capture = i_cmd.cap_en ? {r_capture[DATA_BITS-2:0], i_cmd.sample} : r_capture;
    assign word      = (TRAILING_BITS == 0) ? {n_capture[DATA_BITS-2:0], 1'b0} : n_capture;
    assign word_ext  = 32'(word);

    always_comb begin
        n_sel = 1'b0;
        n_lo  = 1'b0;
        n_drv = 1'b0;
        unique case (i_cmd.phase)
            PH_HEADER: begin
                n_lo  = r_header[HEADER_BITS-1];
                n_drv = 1'b1;
            end
            PH_TURN: begin
                n_drv = 1'b0;
            end
            PH_DATA: begin
                n_lo  = !r_read && r_data[DATA_BITS-1];
                n_drv = !r_read;
            end
            PH_TRAIL: begin
                n_sel = 1'b1;
            end
            default: begin
                n_sel = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_header  <= HEADER_BITS'({8'd0, i_cmd.is_read, i_cmd.addr});
            r_data    <= DATA_BITS'(i_cmd.wdata);
            r_capture <= '0;
            r_read    <= i_cmd.is_read;
        end else if (do_tick) begin
            r_capture <= n_capture;
            if (i_cmd.phase == PH_HEADER) begin
                r_header <= r_header << 1;
            end
            if (i_cmd.phase == PH_DATA) begin
                r_data <= r_data << 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_tick) begin
            r_sel  <= n_sel;
            r_lo   <= n_lo;
            r_drv  <= n_drv;
            r_word <= i_cmd.last ? word_ext[WORD_W-1:0] : '0;
            r_last <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_tick) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_select_n   = r_sel;
    assign o_line_out   = r_lo;
    assign o_line_drive = r_drv;
    assign o_read_word  = r_word;
    assign o_last       = r_last;

endmodule

### test/tb_three_wire_spi_register_master.sv
// self-checking testbench for the three-wire spi register master: predicts pin results
`timescale 1ns / 1ps

module tb_three_wire_spi_register_master;
    import tw_spi_pkg::*;

    localparam int HDR_BITS       = DEF_HEADER_BITS;
    localparam int TURN_BITS      = DEF_TURNAROUND_BITS;
    localparam int DATA_BITS_TB   = DEF_DATA_BITS;
    localparam int TRAIL_BITS     = DEF_TRAILING_BITS;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 200;
    localparam int TARGET_ITEMS   = 1100;

    typedef enum int {
        SAMPLE_RANDOM,
        SAMPLE_ONES,
        SAMPLE_ZEROS
    } sample_mode_e;

    typedef struct {
        bit              sel_n;
        bit              line_out;
        bit              line_drive;
        bit [WORD_W-1:0] read_word;
        bit              last;
    } pin_result_t;

    class spi_frame_scoreboard;
        bit                    busy;
        int                    period;
        bit                    rd_mode;
        bit [HDR_BITS-1:0]     header;
        bit [WORD_W-1:0]       write_word;
        bit [DATA_BITS_TB-1:0] captured;
        pin_result_t           pin_q[$];
        int                    n_errors;
        int                    n_effective;
        int                    n_ignored;
        int                    n_results;
        int                    n_read_frames;
        int                    n_write_frames;

        function void note_request(logic kind, logic rd, logic [ADDR_W-1:0] addr,
                                   logic [WORD_W-1:0] wd, logic smp);
            int          d0;
            int          d1;
            int          total;
            pin_result_t r;
            if (kind == REQ_START) begin
                if (busy) begin
                    n_ignored++;
                    return;
                end
                busy       = 1'b1;
                period     = 0;
                rd_mode    = rd;
                header     = {1'b0, rd, addr};
                write_word = wd;
                captured   = '0;
                n_effective++;
                if (rd) n_read_frames++;
                else n_write_frames++;
                return;
            end
            if (!busy) begin
                n_ignored++;
                return;
            end
            n_effective++;
            d0    = HDR_BITS + (rd_mode ? TURN_BITS : 0);
            d1    = d0 + DATA_BITS_TB;
            total = d1 + TRAIL_BITS;
            if (period > 0 && period - 1 >= d0 && period - 1 < d1)
                captured = {captured[DATA_BITS_TB-2:0], smp};
            r = '{default: 0};
            if (period < HDR_BITS) begin
                r.line_out   = header[HDR_BITS-1-period];
                r.line_drive = 1'b1;
            end else if (period >= d0 && period < d1 && !rd_mode) begin
                r.line_out   = write_word[DATA_BITS_TB-1-(period-d0)];
                r.line_drive = 1'b1;
            end else if (period >= d1) begin
                r.sel_n = 1'b1;
            end
            if (period + 1 >= total) begin
                r.last      = 1'b1;
                r.read_word = (TRAIL_BITS == 0) ? WORD_W'(captured << 1) : WORD_W'(captured);
                busy        = 1'b0;
                period      = 0;
            end else begin
                period++;
            end
            pin_q.push_back(r);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic last);
            pin_result_t e;
            n_results++;
            if (pin_q.size() == 0) begin
                $error("unexpected result: tdata %h tlast %b", data, last);
                n_errors++;
                return;
            end
            e = pin_q.pop_front();
            if (data[0] !== e.sel_n) begin
                $error("select_n: expected %0d got %0d", e.sel_n, data[0]);
                n_errors++;
            end
            if (data[1] !== e.line_out) begin
                $error("line_out: expected %0d got %0d", e.line_out, data[1]);
                n_errors++;
            end
            if (data[2] !== e.line_drive) begin
                $error("line_drive: expected %0d got %0d", e.line_drive, data[2]);
                n_errors++;
            end
            if (data[18:3] !== e.read_word) begin
                $error("read_word: expected %h got %h", e.read_word, data[18:3]);
                n_errors++;
            end
            if (last !== e.last) begin
                $error("last: expected %0d got %0d", e.last, last);
                n_errors++;
            end
        endfunction

        function int pending();
            return pin_q.size();
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = REQ_TICK;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    spi_frame_scoreboard sb = new();
    int                  burst_left  = 4;
    bit                  hold_req    = 1'b0;
    int                  n_holds     = 0;
    int                  idle_cycles = 0;

    three_wire_spi_register_master u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    function automatic int frame_ticks(input logic rd);
        return HDR_BITS + (rd ? TURN_BITS : 0) + DATA_BITS_TB + TRAIL_BITS;
    endfunction

    task automatic send_req(input logic kind, input logic rd, input logic [ADDR_W-1:0] addr,
                            input logic [WORD_W-1:0] wd, input logic smp);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {7'd0, smp, wd, addr, rd};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(kind, rd, addr, wd, smp);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_tick(input logic smp);
        send_req(REQ_TICK, 1'($urandom_range(0, 1)), ADDR_W'($urandom), WORD_W'($urandom), smp);
    endtask

    // start, then ticks; a start while busy is slipped in now and then if busy_start_odds > 0
    task automatic run_frame(input logic rd, input logic [ADDR_W-1:0] addr,
                             input logic [WORD_W-1:0] wd, input int n_ticks,
                             input sample_mode_e mode, input int busy_start_odds);
        int   k;
        logic smp;
        send_req(REQ_START, rd, addr, wd, 1'($urandom_range(0, 1)));
        for (k = 0; k < n_ticks; k++) begin
            if (busy_start_odds > 0 && $urandom_range(1, busy_start_odds) == 1)
                send_req(REQ_START, 1'($urandom_range(0, 1)), ADDR_W'($urandom),
                         WORD_W'($urandom), 1'($urandom_range(0, 1)));
            case (mode)
                SAMPLE_ONES:  smp = 1'b1;
                SAMPLE_ZEROS: smp = 1'b0;
                default:      smp = 1'($urandom_range(0, 1));
            endcase
            send_tick(smp);
        end
    endtask

    // result side: checks accepted results and stalls on its own pattern
    initial begin
        int cyc;
        int mode;
        int hold;
        cyc  = 0;
        mode = 0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
            if (hold_req) begin
                hold_req = 1'b0;
                hold     = HOLD_CYCLES;
                n_holds++;
            end
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            cyc++;
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ((cyc % 8) < 5);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", idle_cycles);
            $display("FAIL three_wire_spi_register_master");
            $finish;
        end
    end

    initial begin
        int   iter;
        int   pick;
        logic rd;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle ticks, address and data extremes, both directions
        send_tick(1'b1);
        send_tick(1'b0);
        run_frame(1'b0, 7'h7f, 16'hffff, frame_ticks(1'b0), SAMPLE_ONES, 4);
        run_frame(1'b1, 7'h00, 16'h0000, frame_ticks(1'b1), SAMPLE_ONES, 0);
        run_frame(1'b1, 7'h7f, 16'hffff, frame_ticks(1'b1), SAMPLE_ZEROS, 0);
        run_frame(1'b0, 7'h00, 16'h0000, frame_ticks(1'b0), SAMPLE_RANDOM, 0);
        send_req(REQ_START, 1'b1, 7'h2a, 16'h5555, 1'b1);
        send_req(REQ_START, 1'b0, 7'h55, 16'haaaa, 1'b0);
        while (sb.busy) send_tick(1'($urandom_range(0, 1)));

        iter = 0;
        while (sb.n_effective < TARGET_ITEMS) begin
            pick = $urandom_range(0, 99);
            rd   = 1'($urandom_range(0, 1));
            if (iter == 12) hold_req = 1'b1;
            if (pick < 80) begin
                run_frame(rd, ADDR_W'($urandom), WORD_W'($urandom), frame_ticks(rd),
                          SAMPLE_RANDOM, 0);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 3)) send_tick(1'($urandom_range(0, 1)));
            end else begin
                run_frame(rd, ADDR_W'($urandom), WORD_W'($urandom),
                          $urandom_range(0, frame_ticks(rd) + 4), SAMPLE_RANDOM, 8);
                while (sb.busy) send_tick(1'($urandom_range(0, 1)));
            end
            iter++;
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d read and %0d write frames, %0d pin results checked",
                 sb.n_read_frames, sb.n_write_frames, sb.n_results);
        $display("%0d requests ignored while idle or busy, %0d long output stalls",
                 sb.n_ignored, n_holds);
        if (sb.n_errors == 0 && sb.pending() == 0)
            $display("PASS three_wire_spi_register_master");
        else
            $display("FAIL three_wire_spi_register_master");
        $finish;
    end

endmodule

### three_wire_spi_register_master.f
rtl/core/tw_spi_pkg.sv
rtl/core/tw_spi_front.sv
rtl/core/tw_spi_cmd_fifo.sv
rtl/core/tw_spi_back.sv
rtl/core/three_wire_spi_register_master.sv
test/tb_three_wire_spi_register_master.sv
